@@ rtl/hpsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Host name prefix/suffix filter package
// Rule tables, record types and helper functions shared by the filter modules.
// ----------------------------------------------------------------------------
package hpsf_pkg;

	// Longest prefix and longest suffix in any rule, in characters.
	localparam int PRE_CHARS = 9;
	localparam int SUF_CHARS = 13;
	localparam int PRE_BITS  = PRE_CHARS * 8;
	localparam int SUF_BITS  = SUF_CHARS * 8;
	localparam int RLEN_W    = 4;

	// Name length counter; it saturates well above every rule length.
	localparam int              LEN_W   = 5;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	localparam int WEAK_COUNT   = 16;
	localparam int STRONG_COUNT = 8;

	localparam logic SET_WEAK   = 1'b0;
	localparam logic SET_STRONG = 1'b1;

	localparam int MAX_RULES_DEF   = 16;
	localparam int TAIL_WINDOW_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Prefix is left-justified (first character in the top byte); suffix is
	// right-justified (last character in the bottom byte).
	typedef struct packed {
		logic [PRE_BITS-1:0] pre;
		logic [RLEN_W-1:0]   pre_len;
		logic [SUF_BITS-1:0] suf;
		logic [RLEN_W-1:0]   suf_len;
	} rule_t;

	// Per-name record handed from the front end to the matcher. The tail holds
	// the newest character in the bottom byte.
	typedef struct packed {
		logic [SUF_BITS-1:0] tail;
		logic [LEN_W-1:0]    len;
		logic                rule_set;
	} name_tail_t;

	function automatic rule_t make_rule(input logic [PRE_BITS-1:0] pre,
			input logic [RLEN_W-1:0] pre_len, input logic [SUF_BITS-1:0] suf,
			input logic [RLEN_W-1:0] suf_len);
		rule_t r;
		r.pre     = pre << (8 * (PRE_CHARS - int'(pre_len)));
		r.pre_len = pre_len;
		r.suf     = suf;
		r.suf_len = suf_len;
		return r;
	endfunction

	// Suffix bytes are written as ASCII in hex.
	localparam logic [SUF_BITS-1:0] SUF_A = 104'h78626f786c6976652e636f6d;
	localparam logic [SUF_BITS-1:0] SUF_B = 104'h78626f782e636f6d;
	localparam logic [SUF_BITS-1:0] SUF_C = 104'h6d736e2e636f6d;
	localparam logic [SUF_BITS-1:0] SUF_D = 104'h70617373706f72742e6e6574;
	localparam logic [SUF_BITS-1:0] SUF_E = 104'h6e736174632e6e6574;
	localparam logic [SUF_BITS-1:0] SUF_F = 104'h6d6963726f736f66742e636f6d;
	localparam logic [SUF_BITS-1:0] SUF_G = 104'h62696e672e6e6574;
	localparam logic [SUF_BITS-1:0] SUF_NONE = '0;
	localparam logic [PRE_BITS-1:0] PRE_NONE = '0;
	localparam logic [PRE_BITS-1:0] PRE_LOCAL = 72'h6c6f63616c686f7374;

	localparam rule_t WEAK_RULES [WEAK_COUNT] = '{
		make_rule(72'h78656d616373, 4'd6, SUF_A, 4'd12),
		make_rule(72'h78656173,     4'd4, SUF_A, 4'd12),
		make_rule(72'h7865746773,   4'd5, SUF_A, 4'd12),
		make_rule(72'h7865786473,   4'd5, SUF_A, 4'd12),
		make_rule(72'h7069666c63,   4'd5, SUF_A, 4'd12),
		make_rule(72'h7369666c63,   4'd5, SUF_A, 4'd12),
		make_rule(72'h6d736163,     4'd4, SUF_A, 4'd12),
		make_rule(72'h786c696e6b,   4'd5, SUF_A, 4'd12),
		make_rule(72'h7875616373,   4'd5, SUF_A, 4'd12),
		make_rule(72'h737473,       4'd3, SUF_A, 4'd12),
		make_rule(72'h78616d,       4'd3, SUF_A, 4'd12),
		make_rule(72'h6e6f74696365, 4'd6, SUF_B, 4'd8),
		make_rule(72'h6d616373,     4'd4, SUF_B, 4'd8),
		make_rule(72'h726164,       4'd3, SUF_C, 4'd7),
		make_rule(PRE_NONE,         4'd0, SUF_D, 4'd12),
		make_rule(PRE_LOCAL,        4'd9, SUF_NONE, 4'd0)
	};

	localparam rule_t STRONG_RULES [STRONG_COUNT] = '{
		make_rule(PRE_NONE,  4'd0, SUF_A, 4'd12),
		make_rule(PRE_NONE,  4'd0, SUF_B, 4'd8),
		make_rule(PRE_NONE,  4'd0, SUF_E, 4'd9),
		make_rule(PRE_NONE,  4'd0, SUF_F, 4'd13),
		make_rule(PRE_NONE,  4'd0, SUF_D, 4'd12),
		make_rule(PRE_NONE,  4'd0, SUF_G, 4'd8),
		make_rule(PRE_NONE,  4'd0, SUF_C, 4'd7),
		make_rule(PRE_LOCAL, 4'd9, SUF_NONE, 4'd0)
	};

	// Rule in slot idx of the chosen set; all zero past the end of the table.
	function automatic rule_t get_rule(input logic sel, input int unsigned idx);
		rule_t r;
		r = '0;
		if (sel == SET_STRONG) begin
			if (idx < STRONG_COUNT)
				r = STRONG_RULES[idx[$clog2(STRONG_COUNT)-1:0]];
		end else begin
			if (idx < WEAK_COUNT)
				r = WEAK_RULES[idx[$clog2(WEAK_COUNT)-1:0]];
		end
		return r;
	endfunction

	// A slot takes part only if it lies inside the chosen table and the slot count.
	function automatic logic rule_valid(input logic sel, input int unsigned idx,
			input int unsigned max_rules);
		int unsigned count;
		count = (sel == SET_STRONG) ? STRONG_COUNT : WEAK_COUNT;
		return (idx < count) && (idx < max_rules);
	endfunction

endpackage

@@ rtl/hpsf_front.sv @@
// ----------------------------------------------------------------------------
// Host name filter front end
// Folds case, tracks prefix progress per rule slot, keeps the tail window and
// the name length, and emits one record per name on its final character.
// ----------------------------------------------------------------------------
module hpsf_front import hpsf_pkg::*; #(
	parameter int MAX_RULES   = MAX_RULES_DEF,
	parameter int TAIL_WINDOW = TAIL_WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rule_set,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           host_char,
	input  logic                 last_char,
	output logic                 rec_push,
	input  logic                 rec_full,
	output logic [MAX_RULES-1:0] rec_pre_ok,
	output name_tail_t           rec_tail
);

	logic [MAX_RULES-1:0]        alive_q;
	logic [MAX_RULES-1:0]        alive_next;
	logic [LEN_W-1:0]            len_q;
	logic [LEN_W-1:0]            len_next;
	logic [TAIL_WINDOW-1:0][7:0] tail_q;
	logic [TAIL_WINDOW-1:0][7:0] tail_next;
	logic [7:0]                  c;
	logic                        accept;

	assign in_stall = rec_full;
	assign accept   = in_valid & ~in_stall;
	assign rec_push = accept & last_char;

	assign c         = (host_char >= 8'h41 && host_char <= 8'h5a) ? (host_char | 8'h20)
	                                                               : host_char;
	assign len_next  = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
	assign tail_next = {tail_q[TAIL_WINDOW-2:0], c};

	for (genvar i = 0; i < MAX_RULES; i++) begin : g_slot
		rule_t r;
		logic  valid;
		logic  miss;

		always_comb begin
			r     = get_rule(rule_set, i);
			valid = rule_valid(rule_set, i, MAX_RULES);
			miss  = 1'b0;
			for (int j = 0; j < PRE_CHARS; j++) begin
				if (len_q == LEN_W'(j) && LEN_W'(j) < {1'b0, r.pre_len}
						&& r.pre[(PRE_CHARS-1-j)*8 +: 8] != c)
					miss = 1'b1;
			end
			alive_next[i] = alive_q[i] & ~(valid & miss);
			rec_pre_ok[i] = valid & alive_next[i] & (len_next >= {1'b0, r.pre_len});
		end
	end

	assign rec_tail.tail     = tail_next[SUF_CHARS-1:0];
	assign rec_tail.len      = len_next;
	assign rec_tail.rule_set = rule_set;

	// Per-name state returns to its reset value after the final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
			len_q   <= '0;
			tail_q  <= '0;
		end else if (accept) begin
			if (last_char) begin
				alive_q <= '1;
				len_q   <= '0;
				tail_q  <= '0;
			end else begin
				alive_q <= alive_next;
				len_q   <= len_next;
				tail_q  <= tail_next;
			end
		end
	end

endmodule

@@ rtl/hpsf_queue.sv @@
// ----------------------------------------------------------------------------
// Host name filter record queue
// Small first-word-fall-through queue between the front end and the matcher.
// ----------------------------------------------------------------------------
module hpsf_queue import hpsf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data,
	input  logic             pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_FULL);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push & ~full;
	assign do_pop   = pop & rd_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/hpsf_back.sv @@
// ----------------------------------------------------------------------------
// Host name filter matcher
// Checks every rule suffix against the name tail and registers the verdict.
// ----------------------------------------------------------------------------
module hpsf_back import hpsf_pkg::*; #(
	parameter int MAX_RULES = MAX_RULES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  logic [MAX_RULES-1:0] q_pre_ok,
	input  name_tail_t           q_tail,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 blocked
);

	logic [MAX_RULES-1:0] suf_ok;
	logic                 hit;
	logic                 out_valid_q;
	logic                 blocked_q;

	for (genvar i = 0; i < MAX_RULES; i++) begin : g_slot
		rule_t r;

		always_comb begin
			r         = get_rule(q_tail.rule_set, i);
			suf_ok[i] = 1'b1;
			if (r.suf_len != '0) begin
				if ({1'b0, r.suf_len} > q_tail.len)
					suf_ok[i] = 1'b0;
				for (int k = 0; k < SUF_CHARS; k++) begin
					if (RLEN_W'(k) < r.suf_len && r.suf[k*8 +: 8] != q_tail.tail[k*8 +: 8])
						suf_ok[i] = 1'b0;
				end
			end
		end
	end

	assign hit   = |(q_pre_ok & suf_ok);
	assign q_pop = q_valid & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			blocked_q <= hit;
	end

	assign out_valid = out_valid_q;
	assign blocked   = blocked_q;

endmodule

@@ rtl/hostname_prefix_suffix_filter_core.sv @@
// ----------------------------------------------------------------------------
// Host name prefix/suffix filter core
// Streams a host name one character at a time and reports whether it is blocked.
// ----------------------------------------------------------------------------
// The block takes one character of a host name per input transaction, with
// last_char high on the final character, and answers each name with exactly
// one output transaction whose blocked bit is high when some rule of the
// selected rule set matches. A rule has an optional prefix and an optional
// suffix, compared without regard to ASCII letter case; an absent part always
// matches, and a part longer than the name never does. rule_set (reset value
// 1) picks the strong eight-rule table, 0 picks the weak sixteen-rule table;
// write it only while no name is in flight. Characters are accepted at one
// per clock, back to back, across name boundaries, while the queue has room.
// On the final character the front end hands a per-name record to a
// two-entry queue, and the matcher takes it from there and registers its
// answer. The queue lets the front end keep taking characters while a
// verdict waits for the consumer; input stalls only when the queue is full,
// which takes two names stacked up behind a stalled output.
// ----------------------------------------------------------------------------
module hostname_prefix_suffix_filter_core import hpsf_pkg::*; #(
	parameter int MAX_RULES   = MAX_RULES_DEF,
	parameter int TAIL_WINDOW = TAIL_WINDOW_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rule_set_we,
	input  logic       rule_set_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] host_char,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       blocked
);

	localparam int REC_W = MAX_RULES + $bits(name_tail_t);

	logic                 rule_set_q;

	// Front end to queue.
	logic                 rec_push;
	logic                 rec_full;
	logic [MAX_RULES-1:0] rec_pre_ok;
	name_tail_t           rec_tail;

	// Queue to matcher.
	logic                 q_valid;
	logic                 q_pop;
	logic [REC_W-1:0]     q_data;
	logic [MAX_RULES-1:0] q_pre_ok;
	name_tail_t           q_tail;

	// The rule set register; only the low bit of the write data exists.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_set_q <= SET_STRONG;
		end else if (rule_set_we) begin
			rule_set_q <= rule_set_wdata;
		end
	end

	// The front end tracks prefix progress and the tail of the name; on the
	// final character it pushes the prefix verdicts and the tail.
	hpsf_front #(
		.MAX_RULES   (MAX_RULES),
		.TAIL_WINDOW (TAIL_WINDOW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rule_set   (rule_set_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.host_char  (host_char),
		.last_char  (last_char),
		.rec_push   (rec_push),
		.rec_full   (rec_full),
		.rec_pre_ok (rec_pre_ok),
		.rec_tail   (rec_tail)
	);

	hpsf_queue #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH_DEF)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rec_push),
		.wr_data  ({rec_pre_ok, rec_tail}),
		.full     (rec_full),
		.rd_valid (q_valid),
		.rd_data  (q_data),
		.pop      (q_pop)
	);

	assign q_pre_ok = q_data[REC_W-1 -: MAX_RULES];
	assign q_tail   = q_data[$bits(name_tail_t)-1:0];

	// The matcher finishes the suffix checks and holds the verdict until taken.
	hpsf_back #(
		.MAX_RULES (MAX_RULES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pre_ok  (q_pre_ok),
		.q_tail    (q_tail),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.blocked   (blocked)
	);

endmodule

@@ verif/tb_hostname_prefix_suffix_filter_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Host name prefix/suffix filter core testbench
// Streams host names into the filter, predicts every verdict and checks it.
// ----------------------------------------------------------------------------

// Suffix texts, right-justified: the final character sits in the bottom byte.
localparam bit [103:0] SFX_A = 104'h78626f786c6976652e636f6d;
localparam bit [103:0] SFX_B = 104'h78626f782e636f6d;
localparam bit [103:0] SFX_C = 104'h6d736e2e636f6d;
localparam bit [103:0] SFX_D = 104'h70617373706f72742e6e6574;
localparam bit [103:0] SFX_E = 104'h6e736174632e6e6574;
localparam bit [103:0] SFX_F = 104'h6d6963726f736f66742e636f6d;
localparam bit [103:0] SFX_G = 104'h62696e672e6e6574;

localparam int SLOTS       = 16;
localparam int WINDOW      = 16;
localparam bit [4:0] SAT   = 5'd31;

typedef struct {
	bit [71:0]  pre;
	int         pre_n;
	bit [103:0] suf;
	int         suf_n;
} filter_rule_t;

function automatic int slot_count(bit sel);
	return (sel == hpsf_pkg::SET_STRONG) ? 8 : 16;
endfunction

function automatic filter_rule_t lookup_rule(bit sel, int idx);
	filter_rule_t r;
	r = '{72'h0, 0, 104'h0, 0};
	if (sel == hpsf_pkg::SET_STRONG) begin
		case (idx)
			0: r = '{72'h0, 0, SFX_A, 12};
			1: r = '{72'h0, 0, SFX_B, 8};
			2: r = '{72'h0, 0, SFX_E, 9};
			3: r = '{72'h0, 0, SFX_F, 13};
			4: r = '{72'h0, 0, SFX_D, 12};
			5: r = '{72'h0, 0, SFX_G, 8};
			6: r = '{72'h0, 0, SFX_C, 7};
			7: r = '{"localhost", 9, 104'h0, 0};
			default: ;
		endcase
	end else begin
		case (idx)
			0:  r = '{"xemacs", 6, SFX_A, 12};
			1:  r = '{"xeas", 4, SFX_A, 12};
			2:  r = '{"xetgs", 5, SFX_A, 12};
			3:  r = '{"xexds", 5, SFX_A, 12};
			4:  r = '{"piflc", 5, SFX_A, 12};
			5:  r = '{"siflc", 5, SFX_A, 12};
			6:  r = '{"msac", 4, SFX_A, 12};
			7:  r = '{"xlink", 5, SFX_A, 12};
			8:  r = '{"xuacs", 5, SFX_A, 12};
			9:  r = '{"sts", 3, SFX_A, 12};
			10: r = '{"xam", 3, SFX_A, 12};
			11: r = '{"notice", 6, SFX_B, 8};
			12: r = '{"macs", 4, SFX_B, 8};
			13: r = '{"rad", 3, SFX_C, 7};
			14: r = '{72'h0, 0, SFX_D, 12};
			15: r = '{"localhost", 9, 104'h0, 0};
			default: ;
		endcase
	end
	return r;
endfunction

// Tracks the name being received, holds the verdicts still owed by the block
// and compares each verdict that comes out against the oldest one.
class verdict_board;
	bit       rule_sel;
	bit       alive [SLOTS];
	bit [4:0] pos;
	bit [4:0] len_seen;
	bit [7:0] tail [WINDOW];
	bit       expected_q [$];
	int       errors;

	function void clear_name();
		for (int i = 0; i < SLOTS; i++)
			alive[i] = 1'b1;
		for (int k = 0; k < WINDOW; k++)
			tail[k] = 8'h00;
		pos = '0;
		len_seen = '0;
	endfunction

	function void reset_all();
		rule_sel = hpsf_pkg::SET_STRONG;
		clear_name();
		expected_q.delete();
		errors = 0;
	endfunction

	function bit suffix_fits(filter_rule_t r);
		if (r.suf_n == 0)
			return 1'b1;
		if (r.suf_n > len_seen || r.suf_n > WINDOW)
			return 1'b0;
		for (int k = 0; k < r.suf_n; k++)
			if (r.suf[8*k +: 8] != tail[WINDOW-1-k])
				return 1'b0;
		return 1'b1;
	endfunction

	// Called for every accepted character transaction.
	function void note_char(bit [7:0] raw, bit last);
		bit [7:0]     ch;
		bit           hit;
		filter_rule_t r;
		// Only ASCII capitals fold; every other byte stands as it is.
		ch = (raw >= 8'h41 && raw <= 8'h5a) ? raw + 8'h20 : raw;
		for (int i = 0; i < slot_count(rule_sel); i++) begin
			r = lookup_rule(rule_sel, i);
			if (int'(pos) < r.pre_n && r.pre[8*(r.pre_n-1-int'(pos)) +: 8] != ch)
				alive[i] = 1'b0;
		end
		for (int k = 0; k < WINDOW-1; k++)
			tail[k] = tail[k+1];
		tail[WINDOW-1] = ch;
		if (pos < SAT)
			pos++;
		if (len_seen < SAT)
			len_seen++;
		if (!last)
			return;
		hit = 1'b0;
		for (int i = 0; i < slot_count(rule_sel); i++) begin
			r = lookup_rule(rule_sel, i);
			if (alive[i] && len_seen >= r.pre_n && suffix_fits(r))
				hit = 1'b1;
		end
		expected_q.push_back(hit);
		clear_name();
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task check_verdict(logic got);
		bit want;
		if (expected_q.size() == 0) begin
			report_mismatch("verdict with no name pending");
		end else begin
			want = expected_q.pop_front();
			if (got !== want)
				report_mismatch($sformatf("blocked=%b, expected %b", got, want));
		end
	endtask
endclass

module tb_hostname_prefix_suffix_filter_core;

	// The verdict is registered in the matcher, behind the record queue, after the last character is taken.
	localparam int VERDICT_LATENCY = 1;

	logic       clk;
	logic       arst_n;
	logic       rule_set_we;
	logic       rule_set_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] host_char;
	logic       last_char;
	logic       out_valid;
	logic       out_stall;
	logic       blocked;

	verdict_board board;

	// Percent chance per cycle that the sender leaves valid low, and that the
	// receiver raises stall. They are changed between phases.
	int send_idle_pct;
	int recv_idle_pct;
	// Forces the receiver to stall for a long stretch, so the block backs up.
	logic rx_hold;

	int         chars_sent;
	bit [7:0]   name_buf [$];

	hostname_prefix_suffix_filter_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.rule_set_we    (rule_set_we),
		.rule_set_wdata (rule_set_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.host_char      (host_char),
		.last_char      (last_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.blocked        (blocked)
	);

	always #10 clk = ~clk;

	// Receiver. Values are sampled at the edge before any update lands, so a
	// verdict counts as taken exactly when out_valid was high and our stall low.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			board.check_verdict(blocked);
		out_stall <= rx_hold || ($urandom_range(99) < recv_idle_pct);
	end

	// Offers one character and returns on the edge that accepts it. The valid
	// line is left high; the next call either replaces the payload in the same
	// step or drops valid, so a character is never taken twice.
	task automatic send_char(input bit [7:0] ch, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		host_char <= ch;
		last_char <= last;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		board.note_char(ch, last);
		chars_sent++;
	endtask

	task automatic send_buf();
		for (int i = 0; i < name_buf.size(); i++)
			send_char(name_buf[i], i == name_buf.size() - 1);
	endtask

	// Stops offering, waits for every owed verdict, then lets the pipeline
	// settle a little longer so nothing is in flight.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (VERDICT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_rule_set(input bit sel);
		rule_set_we    <= 1'b1;
		rule_set_wdata <= sel;
		@(posedge clk);
		rule_set_we <= 1'b0;
		board.rule_sel = sel;
	endtask

	function automatic bit [7:0] mix_case(bit [7:0] ch);
		if (ch >= 8'h61 && ch <= 8'h7a && $urandom_range(1))
			return ch - 8'h20;
		return ch;
	endfunction

	// Typical host name filler: letters, digits and dots.
	function automatic bit [7:0] filler_char();
		case ($urandom_range(3))
			0:       return 8'h2e;
			1:       return 8'h30 + 8'($urandom_range(9));
			default: return mix_case(8'h61 + 8'($urandom_range(25)));
		endcase
	endfunction

	task automatic put_text(input bit [103:0] text, input int n);
		for (int j = 0; j < n; j++)
			name_buf.push_back(mix_case(text[8*(n-1-j) +: 8]));
	endtask

	task automatic put_filler(input int n);
		repeat (n) name_buf.push_back(filler_char());
	endtask

	// Builds a name that some rule of the given set accepts: prefix, pad,
	// suffix. A prefix-only rule gets the pad after it, a suffix-only rule
	// before it.
	task automatic build_rule_name(input bit sel, input int pad);
		filter_rule_t r;
		r = lookup_rule(sel, $urandom_range(slot_count(sel) - 1));
		name_buf.delete();
		put_text({32'h0, r.pre}, r.pre_n);
		put_filler(pad);
		put_text(r.suf, r.suf_n);
	endtask

	task automatic build_random_name();
		int kind;
		int cut;
		kind = $urandom_range(99);
		if (kind < 50) begin
			// Well-formed names, a quarter of them with one byte spoiled.
			build_rule_name(board.rule_sel, $urandom_range(3));
			if ($urandom_range(3) == 0)
				name_buf[$urandom_range(name_buf.size() - 1)] = 8'($urandom_range(255));
		end else if (kind < 60) begin
			// A rule of the other set, which the selected set may not know.
			build_rule_name(!board.rule_sel, $urandom_range(3));
		end else if (kind < 70) begin
			// Chopped names: shorter than the prefix or the suffix they carry.
			build_rule_name(board.rule_sel, $urandom_range(3));
			cut = $urandom_range(name_buf.size() - 1, 1);
			if ($urandom_range(1))
				repeat (cut) void'(name_buf.pop_front());
			else
				repeat (cut) void'(name_buf.pop_back());
		end else if (kind < 85) begin
			name_buf.delete();
			repeat ($urandom_range(6, 1)) name_buf.push_back(8'($urandom_range(255)));
		end else if (kind < 92) begin
			// Long names, many of them long enough to saturate the position and length counters.
			build_rule_name(board.rule_sel, $urandom_range(35, 20));
		end else begin
			name_buf.delete();
			name_buf.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(input int target);
		int start;
		start = chars_sent;
		while (chars_sent - start < target) begin
			build_random_name();
			send_buf();
		end
	endtask

	// Holds the receiver off for a long stretch while the sender keeps
	// pushing short names, so the verdict queue fills and input stalls.
	task automatic squeeze_output();
		fork
			begin
				rx_hold <= 1'b1;
				repeat (300) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (40) begin
			name_buf.delete();
			repeat ($urandom_range(2, 1)) name_buf.push_back(8'($urandom_range(255)));
			send_buf();
		end
	endtask

	initial begin
		board = new;
		board.reset_all();
		clk            = 1'b0;
		arst_n         = 1'b0;
		rule_set_we    = 1'b0;
		rule_set_wdata = 1'b0;
		in_valid       = 1'b0;
		host_char      = 8'h00;
		last_char      = 1'b0;
		out_stall      = 1'b0;
		rx_hold        = 1'b0;
		chars_sent     = 0;
		send_idle_pct  = 33;
		recv_idle_pct  = 85;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed names under the reset value of the register (strong set).
		// A zero byte and an all-ones byte, each a whole one-character name.
		name_buf = '{8'h00};
		send_buf();
		name_buf = '{8'hff};
		send_buf();
		// Prefix-only rule written in mixed case.
		name_buf.delete();
		put_text("LocalHost", 9);
		send_buf();
		// One character short of that prefix, so it must not match.
		name_buf.delete();
		put_text("localhos", 8);
		send_buf();
		// The bytes just outside the capital range do not fold.
		name_buf = '{8'h40, 8'h5b};
		send_buf();

		// Weak set, slow receiver.
		quiesce();
		write_rule_set(hpsf_pkg::SET_WEAK);
		run_random(350);

		// Strong set, slow sender.
		quiesce();
		write_rule_set(hpsf_pkg::SET_STRONG);
		send_idle_pct = 85;
		recv_idle_pct = 33;
		run_random(350);

		// Weak set at full rate with a long output hold-off.
		quiesce();
		write_rule_set(hpsf_pkg::SET_WEAK);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		squeeze_output();
		run_random(200);

		// Strong set at full rate; another hold-off, then a full drain pause.
		quiesce();
		write_rule_set(hpsf_pkg::SET_STRONG);
		run_random(120);
		squeeze_output();
		quiesce();
		run_random(120);

		quiesce();
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: the slowest honest run is far below this.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/hpsf_pkg.sv
rtl/hpsf_front.sv
rtl/hpsf_queue.sv
rtl/hpsf_back.sv
rtl/hostname_prefix_suffix_filter_core.sv
verif/tb_hostname_prefix_suffix_filter_core.sv
